[rtl/mcdm_pkg.sv]
`timescale 1ns / 1ps
package mcdm_pkg;

    localparam int MaxDetections = 16;
    localparam int NearLimitMm   = 999;
    localparam logic [15:0] MergeDistanceReset = 16'd200;
    localparam logic [15:0] HoldTimeReset      = 16'd300;

    localparam logic CfgMergeDistance = 1'b0;
    localparam logic CfgHoldTime      = 1'b1;

    typedef struct packed {
        logic [3:0]         camera_id;
        logic [15:0]        confidence;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        orientation;
        logic [31:0]        now_ms;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         out_camera;
        logic [15:0]        out_confidence;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]        out_angle;
        logic               out_last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PAIR,
        ST_PICK,
        ST_TRACK,
        ST_NEAR,
        ST_EMIT_CHECK,
        ST_EMIT_SEND,
        ST_DONE
    } t_state;

    // squared distance unit operands
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
    } t_dist_req;

endpackage

[rtl/mcdm_dist.sv]
`timescale 1ns / 1ps
module mcdm_dist (
    input  logic                i_clk,
    input  mcdm_pkg::t_dist_req i_req,
    output logic [33:0]         o_dist_sq
);
    import mcdm_pkg::*;

    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [33:0] w_px;
    logic signed [33:0] w_py;
    logic [33:0]        r_sq_x;
    logic [33:0]        r_sq_y;

    assign w_dx = 17'(i_req.ax) - 17'(i_req.bx);
    assign w_dy = 17'(i_req.ay) - 17'(i_req.by);
    assign w_px = w_dx * w_dx;
    assign w_py = w_dy * w_dy;

    // two-stage: square, then add
    always_ff @(posedge i_clk) begin
        r_sq_x <= unsigned'(w_px);
        r_sq_y <= unsigned'(w_py);
    end

    assign o_dist_sq = r_sq_x + r_sq_y;
endmodule

[rtl/multi_camera_detection_merge.sv]
`timescale 1ns / 1ps
// channel  | direction | signals
// input    | in        | i_in_valid, o_in_stall, i_in_item
// output   | out       | o_out_valid, i_out_stall, o_out_item
// config   | in        | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// a non-final item is stored by a sorted insert that scans held entries
// frame end walks the surviving pairs through one squared-distance unit, then
// runs pick, track check, nearest search if needed and emit over the detections
// reset is synchronous active low; it clears control and tracking and loads config defaults
// the block stalls its input whenever it is not idle: for each item and frame-end work
module multi_camera_detection_merge #(
    parameter int MAX_DET = mcdm_pkg::MaxDetections
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mcdm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mcdm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import mcdm_pkg::*;

    localparam int IW = $clog2(MAX_DET);
    localparam int CW = $clog2(MAX_DET + 1);

    t_state r_state, n_state;

    logic [15:0] r_merge, r_hold;
    logic [31:0] r_pos  [MAX_DET];
    logic [35:0] r_attr [MAX_DET];
    logic [IW-1:0] r_ord [MAX_DET];
    logic [MAX_DET-1:0] r_surv;
    logic [CW-1:0] r_cnt;
    logic signed [15:0] r_tx, r_ty;
    logic r_known;
    logic [31:0] r_timer;
    t_in_item r_in;

    logic [CW-1:0] r_k, r_j, r_p;
    logic [1:0]    r_ph;
    logic [IW-1:0] r_pick, r_chosen;
    logic [33:0]   r_best;
    t_out_item     r_out;
    logic          r_out_v;

    t_dist_req     w_req;
    logic [33:0]   w_d;
    logic [33:0]   w_md2;

    assign w_md2 = 34'(32'(r_merge) * 32'(r_merge));

    mcdm_dist u_dist (.i_clk(i_clk), .i_req(w_req), .o_dist_sq(w_d));

    logic [IW-1:0] w_sa, w_sb;
    assign w_sa = r_ord[r_k[IW-1:0]];
    assign w_sb = (r_state == ST_PAIR) ? r_ord[r_j[IW-1:0]] : r_ord[r_chosen];

    always_comb begin
        w_req.ax = r_pos[w_sa][15:0];
        w_req.ay = r_pos[w_sa][31:16];
        w_req.bx = r_pos[w_sb][15:0];
        w_req.by = r_pos[w_sb][31:16];
        if (r_state == ST_TRACK) begin
            w_req.ax = r_tx;
            w_req.ay = r_ty;
            w_req.bx = r_pos[r_ord[r_pick]][15:0];
            w_req.by = r_pos[r_ord[r_pick]][31:16];
        end else if (r_state == ST_NEAR) begin
            w_req.ax = r_tx;
            w_req.ay = r_ty;
            w_req.bx = r_pos[w_sa][15:0];
            w_req.by = r_pos[w_sa][31:16];
        end
    end

    always_comb begin
        o_in_stall  = !(r_state == ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
        o_out_valid = r_out_v;
        o_out_item  = r_out;
    end

    // sequencer
    logic w_last_k;
    assign w_last_k = (r_k == r_cnt - CW'(1));

    logic w_slot_free;
    assign w_slot_free = !r_out_v || !i_out_stall;

    logic w_use_pick;
    assign w_use_pick = !r_known || (w_d <= w_md2) ||
                        ((r_in.now_ms - r_timer) >= 32'(r_hold));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_INSERT;
            ST_INSERT: begin
                if (r_cnt == CW'(MAX_DET) || r_p == r_cnt ||
                    r_attr[r_ord[r_p[IW-1:0]]][31:16] >= r_in.confidence) begin
                    if (!r_in.frame_end) n_state = ST_IDLE;
                    else if (r_cnt == CW'(MAX_DET) && r_cnt == '0) n_state = ST_IDLE;
                    else n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (r_cnt == '0) n_state = ST_IDLE;
                else if (r_cnt == CW'(1)) n_state = ST_EMIT_CHECK;
                else n_state = ST_PAIR;
            end
            ST_PAIR:  if (r_k >= r_cnt - CW'(1)) n_state = ST_PICK;
            ST_PICK:  if (w_last_k) n_state = ST_TRACK;
            ST_TRACK: if (r_ph == 2'd2) n_state = w_use_pick ? ST_EMIT_CHECK : ST_NEAR;
            ST_NEAR: begin
                if ((!r_surv[r_k[IW-1:0]] || r_ph == 2'd2) && w_last_k)
                    n_state = ST_EMIT_CHECK;
            end
            ST_EMIT_CHECK: if (r_ph == 2'd2 && w_last_k) n_state = ST_EMIT_SEND;
            ST_EMIT_SEND:  if (w_slot_free && w_last_k) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic w_keep;
    assign w_keep = (r_k[IW-1:0] == r_chosen) ||
                    ((r_attr[w_sa][35:32] != r_attr[w_sb][35:32]) && (w_d <= w_md2));

    // find whether any later kept entry exists (for out_last)
    logic w_more;
    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < MAX_DET; i++) begin
            if (CW'(i) > r_k && r_surv[i])
                w_more = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_merge <= MergeDistanceReset;
            r_hold  <= HoldTimeReset;
            r_cnt   <= '0;
            r_surv  <= '0;
            r_tx    <= '0;
            r_ty    <= '0;
            r_known <= 1'b0;
            r_timer <= '0;
            r_out_v <= 1'b0;
            r_k <= '0; r_j <= '0; r_p <= '0; r_ph <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT_SEND && w_slot_free && r_surv[r_k[IW-1:0]])
                r_out_v <= 1'b1;
            else if (!i_out_stall)
                r_out_v <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CfgMergeDistance) r_merge <= i_cfg_data;
                else r_hold <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: if (i_in_valid) begin
                    r_in <= i_in_item;
                    r_p  <= '0;
                end
                ST_INSERT: begin
                    if (n_state != ST_INSERT) begin
                        if (r_cnt != CW'(MAX_DET)) begin
                            r_pos[r_cnt[IW-1:0]]  <= {r_in.pos_y, r_in.pos_x};
                            r_attr[r_cnt[IW-1:0]] <= {r_in.camera_id, r_in.confidence,
                                                      r_in.orientation};
                            for (int i = 0; i < MAX_DET; i++) begin
                                if (CW'(i) == r_p)
                                    r_ord[i] <= r_cnt[IW-1:0];
                                else if (CW'(i) > r_p && CW'(i) <= r_cnt)
                                    r_ord[i] <= r_ord[(i + MAX_DET - 1) % MAX_DET];
                            end
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_k <= '0; r_j <= CW'(1); r_ph <= '0;
                    end else r_p <= r_p + CW'(1);
                end
                ST_DONE: begin
                    for (int i = 0; i < MAX_DET; i++)
                        r_surv[i] <= (CW'(i) < r_cnt);
                    r_chosen <= '0;
                    r_pick <= '0;
                    r_k <= '0; r_j <= CW'(1); r_ph <= '0;
                    if (r_cnt == CW'(1)) r_timer <= r_in.now_ms;
                end
                ST_PAIR: begin
                    if (!r_surv[r_k[IW-1:0]] || r_j >= r_cnt) begin
                        r_ph <= '0;
                        r_k  <= (r_k >= r_cnt - CW'(1)) ? '0 : r_k + CW'(1);
                        r_j  <= r_k + CW'(2);
                    end else if (!r_surv[r_j[IW-1:0]]) begin
                        r_j <= r_j + CW'(1);
                    end else if (r_ph != 2'd2) begin
                        r_ph <= r_ph + 2'd1;
                    end else begin
                        if (r_attr[w_sa][35:32] != r_attr[w_sb][35:32] && w_d <= w_md2)
                            r_surv[r_j[IW-1:0]] <= 1'b0;
                        r_ph <= '0;
                        r_j  <= r_j + CW'(1);
                    end
                end
                ST_PICK: begin
                    if (r_surv[r_k[IW-1:0]]) r_pick <= r_k[IW-1:0];
                    r_k <= w_last_k ? '0 : r_k + CW'(1);
                end
                ST_TRACK: begin
                    r_chosen <= r_pick;
                    r_best   <= 34'(NearLimitMm * NearLimitMm);
                    r_ph     <= (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                    if (r_ph == 2'd2) begin
                        if (w_use_pick) r_timer <= r_in.now_ms;
                        r_k <= '0;
                    end
                end
                ST_NEAR: begin
                    if (r_surv[r_k[IW-1:0]] && r_ph != 2'd2) begin
                        r_ph <= r_ph + 2'd1;
                    end else begin
                        if (r_surv[r_k[IW-1:0]] && w_d < r_best) begin
                            r_best <= w_d;
                            r_chosen <= r_k[IW-1:0];
                        end
                        r_ph <= '0;
                        r_k <= w_last_k ? '0 : r_k + CW'(1);
                    end
                end
                ST_EMIT_CHECK: begin
                    // survivor flags now mark the results to send
                    r_ph <= (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                    if (r_ph == 2'd2) begin
                        r_surv[r_k[IW-1:0]] <= w_keep;
                        r_k <= w_last_k ? '0 : r_k + CW'(1);
                    end
                end
                ST_EMIT_SEND: if (w_slot_free) begin
                    if (r_surv[r_k[IW-1:0]]) begin
                        r_out.out_camera     <= r_attr[w_sa][35:32];
                        r_out.out_confidence <= r_attr[w_sa][31:16];
                        r_out.out_x          <= r_pos[w_sa][15:0];
                        r_out.out_y          <= r_pos[w_sa][31:16];
                        r_out.out_angle      <= r_attr[w_sa][15:0];
                        r_out.out_last       <= !w_more;
                    end
                    r_k <= r_k + CW'(1);
                    if (w_last_k) begin
                        r_tx <= r_pos[r_ord[r_chosen]][15:0];
                        r_ty <= r_pos[r_ord[r_chosen]][31:16];
                        r_known <= 1'b1;
                        r_cnt <= '0;
                        r_surv <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    property p_cfg_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready |-> r_state == ST_IDLE;
    endproperty
    a_cfg_idle: assert property (p_cfg_idle) else $error("config accepted while busy");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DET)) else $error("frame count overflow");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && i_out_stall |=> r_out_v) else $error("result lost under stall");

endmodule
